/* src/kalman_cv_angle_rate_defines.svh */
// Assertion macros for the angle/rate Kalman filter.
`ifndef KALMAN_CV_ANGLE_RATE_DEFINES_SVH
`define KALMAN_CV_ANGLE_RATE_DEFINES_SVH
`ifndef SYNTH
`define KCV_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define KCV_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define KCV_ASSERT_IMP(label, clk, rst_n, a, c)
`define KCV_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* src/kcv_pkg.sv */
// Shared types, codes and constants of the angle/rate Kalman filter.
`default_nettype none
package kcv_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ADDR_W = 5;

    typedef enum logic [1:0] {
        KIND_INIT    = 2'd0,
        KIND_PREDICT = 2'd1,
        KIND_UPDATE  = 2'd2,
        KIND_FORCE   = 2'd3
    } kind_t;

    localparam logic [ADDR_W-1:0] ADDR_QAA = 5'd0;
    localparam logic [ADDR_W-1:0] ADDR_QAR = 5'd4;
    localparam logic [ADDR_W-1:0] ADDR_QRA = 5'd8;
    localparam logic [ADDR_W-1:0] ADDR_QRR = 5'd12;
    localparam logic [ADDR_W-1:0] ADDR_RN  = 5'd16;

    // Datapath operations, one per sequencer step.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_FORCE,
        OP_P_MUL_VC,   // m = v*c -> t0 = a + m
        OP_P_MUL_VD,   // m = v*d -> t1 = b + m, t2 = c + m
        OP_P_MUL_VT1,  // m = v*t1 -> a' = t0 + m + Qaa
        OP_P_MUL_VR,   // m = v*rate -> angle += m, commit cov
        OP_U_CHECK,    // S = a + R, latch y
        OP_U_DIV0,     // start k0 division
        OP_U_K0,       // latch k0, start k1 division
        OP_U_K1,       // latch k1
        OP_U_MUL_K0Y,
        OP_U_MUL_K1Y,
        OP_U_MUL_K0A,
        OP_U_MUL_K0B,
        OP_U_MUL_K1A,
        OP_U_MUL_K1B
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic mul_start;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic s_bad;
    } stat_t;

    // Clamp a 66-bit signed value to 32 bits.
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) r = {1'b1, 32'h7fffffff};
        else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
        else r = {1'b0, v[31:0]};
        return r;
    endfunction
endpackage
`default_nettype wire

/* src/kcv_mul.sv */
// Registered signed 32x32 fixed-point multiplier with floor and clamp.
`default_nettype none
module kcv_mul #(
    parameter int FRAC_BITS = kcv_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] x,
    input  wire logic signed [31:0] y,
    output logic                    done,
    output logic signed [31:0]      q,
    output logic                    clamp
);
    import kcv_pkg::*;
    logic signed [63:0] prod_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [63:0] shifted;
    logic [32:0]        s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= x * y;
    end

    // Arithmetic shift floors for both signs.
    assign shifted = prod_reg >>> FRAC_BITS;
    assign s       = sat32(66'(shifted));
    assign done    = done_reg;
    assign q       = s[31:0];
    assign clamp   = s[32];
endmodule
`default_nettype wire

/* src/kcv_div.sv */
// Restoring divider for the gain: trunc(num * 2^FRAC_BITS / den), clamped.
`default_nettype none
module kcv_div #(
    parameter int FRAC_BITS = kcv_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic        [32:0] den,
    output logic                    done,
    output logic signed [31:0]      q,
    output logic                    clamp
);
    import kcv_pkg::*;
    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] dvd_reg;
    logic [33:0]   rem_reg;
    logic [32:0]   den_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [31:0]   mag;
    logic [34:0]   trial;
    logic signed [65:0] sq;
    logic [32:0]   s;

    assign mag   = num[31] ? 32'(-num) : 32'(num);
    assign trial = {rem_reg, dvd_reg[NW-1]} - {2'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One quotient bit a cycle; quotient bits shift into the dividend word.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[31];
        end
        else if (busy_reg)
        begin
            if (!trial[34])
            begin
                rem_reg <= trial[33:0];
                dvd_reg <= {dvd_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[32:0], dvd_reg[NW-1]};
                dvd_reg <= {dvd_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign sq    = neg_reg ? -66'($unsigned(dvd_reg)) : 66'($unsigned(dvd_reg));
    assign s     = sat32(sq);
    assign done  = done_reg;
    assign q     = s[31:0];
    assign clamp = s[32];
endmodule
`default_nettype wire

/* src/kcv_datapath.sv */
// State registers, operand selection and result logic of the filter.
`default_nettype none
module kcv_datapath #(
    parameter int FRAC_BITS = kcv_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kcv_pkg::cmd_t      cmd,
    output kcv_pkg::stat_t          stat,
    input  wire logic               in_load,
    input  wire logic signed [31:0] in_value,
    input  wire logic signed [31:0] qaa,
    input  wire logic signed [31:0] qar,
    input  wire logic signed [31:0] qra,
    input  wire logic signed [31:0] qrr,
    input  wire logic        [30:0] rn,
    output logic signed [31:0]      angle_out,
    output logic signed [31:0]      rate_out,
    output logic                    sing_out,
    output logic                    sat_out
);
    import kcv_pkg::*;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0] ang_reg, rate_reg, a_reg, b_reg, c_reg, d_reg;
    logic signed [31:0] v_reg, t0_reg, t1_reg, t2_reg, y_reg, k0_reg, k1_reg;
    logic        [32:0] s_reg;
    logic               sat_reg, sing_reg, yc_reg;
    logic signed [31:0] mx, my, mq, dq;
    logic               mdone, mclamp, ddone, dclamp;
    logic signed [31:0] dnum;
    logic        [32:0] s_next;

    function automatic logic [32:0] add2(input logic signed [31:0] p,
                                         input logic signed [31:0] r);
        return sat32(66'(p) + 66'(r));
    endfunction
    function automatic logic [32:0] sub2(input logic signed [31:0] p,
                                         input logic signed [31:0] r);
        return sat32(66'(p) - 66'(r));
    endfunction

    always_comb
    begin
        mx = v_reg;
        my = c_reg;
        case (cmd.op)
            OP_P_MUL_VD:  my = d_reg;
            OP_P_MUL_VT1: my = t1_reg;
            OP_P_MUL_VR:  my = rate_reg;
            OP_U_MUL_K0Y: begin mx = k0_reg; my = y_reg; end
            OP_U_MUL_K1Y: begin mx = k1_reg; my = y_reg; end
            OP_U_MUL_K0A: begin mx = k0_reg; my = a_reg; end
            OP_U_MUL_K0B: begin mx = k0_reg; my = b_reg; end
            OP_U_MUL_K1A: begin mx = k1_reg; my = a_reg; end
            OP_U_MUL_K1B: begin mx = k1_reg; my = b_reg; end
            default: ;
        endcase
    end

    kcv_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(cmd.mul_start), .x(mx), .y(my),
        .done(mdone), .q(mq), .clamp(mclamp)
    );

    assign dnum = (cmd.op == OP_U_DIV0) ? a_reg : c_reg;
    kcv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .num(dnum), .den(s_reg),
        .done(ddone), .q(dq), .clamp(dclamp)
    );

    assign s_next = 33'(33'(signed'(a_reg)) + 33'({1'b0, rn}));
    assign stat = '{mul_done: mdone, div_done: ddone, s_bad: s_reg[32] || s_reg == '0};

    // Cycle-by-cycle register update; each step records any clamp it sees.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_reg  <= '0;
            rate_reg <= '0;
            a_reg    <= ONE;
            b_reg    <= '0;
            c_reg    <= '0;
            d_reg    <= ONE;
            sat_reg  <= 1'b0;
            sing_reg <= 1'b0;
        end
        else
        begin
            logic [32:0] r0, r1, r2;
            r0 = '0; r1 = '0; r2 = '0;
            if (in_load)
            begin
                v_reg    <= in_value;
                sat_reg  <= 1'b0;
                sing_reg <= 1'b0;
            end
            case (cmd.op)
                OP_INIT:
                begin
                    ang_reg <= v_reg; rate_reg <= '0;
                    a_reg <= ONE; b_reg <= '0; c_reg <= '0; d_reg <= ONE;
                end
                OP_FORCE: ang_reg <= v_reg;
                OP_P_MUL_VC:
                    if (mdone)
                    begin
                        r0 = add2(a_reg, mq); t0_reg <= r0[31:0];
                        sat_reg <= sat_reg | mclamp | r0[32];
                    end
                OP_P_MUL_VD:
                    if (mdone)
                    begin
                        r0 = add2(b_reg, mq); r1 = add2(c_reg, mq);
                        t1_reg <= r0[31:0]; t2_reg <= r1[31:0];
                        sat_reg <= sat_reg | mclamp | r0[32] | r1[32];
                    end
                OP_P_MUL_VT1:
                    if (mdone)
                    begin
                        r0 = add2(t0_reg, mq); r1 = add2(r0[31:0], qaa);
                        t0_reg <= r1[31:0];
                        sat_reg <= sat_reg | mclamp | r0[32] | r1[32];
                    end
                OP_P_MUL_VR:
                    if (mdone)
                    begin
                        logic [32:0] r3, r4;
                        r0 = add2(ang_reg, mq); r1 = add2(t1_reg, qar);
                        r2 = add2(t2_reg, qra); r3 = add2(d_reg, qrr);
                        r4 = '0;
                        ang_reg <= r0[31:0]; a_reg <= t0_reg; b_reg <= r1[31:0];
                        c_reg <= r2[31:0]; d_reg <= r3[31:0];
                        sat_reg <= sat_reg | mclamp | r0[32] | r1[32] | r2[32]
                                   | r3[32] | r4[32];
                    end
                OP_U_CHECK:
                begin
                    r0 = sub2(v_reg, ang_reg);
                    y_reg  <= r0[31:0];
                    yc_reg <= r0[32];
                    s_reg  <= s_next;
                end
                // The innovation clamp counts only when the update goes ahead.
                OP_U_DIV0:
                begin
                    sing_reg <= stat.s_bad;
                    if (!stat.s_bad) sat_reg <= sat_reg | yc_reg;
                end
                OP_U_K0:
                    if (ddone)
                    begin
                        k0_reg <= dq;
                        sat_reg <= sat_reg | dclamp;
                    end
                OP_U_K1:
                    if (ddone)
                    begin
                        k1_reg <= dq;
                        sat_reg <= sat_reg | dclamp;
                    end
                OP_U_MUL_K0Y:
                    if (mdone)
                    begin
                        r0 = add2(ang_reg, mq); ang_reg <= r0[31:0];
                        sat_reg <= sat_reg | mclamp | r0[32];
                    end
                OP_U_MUL_K1Y:
                    if (mdone)
                    begin
                        r0 = add2(rate_reg, mq); rate_reg <= r0[31:0];
                        sat_reg <= sat_reg | mclamp | r0[32];
                    end
                OP_U_MUL_K0A:
                    if (mdone)
                    begin
                        r0 = sub2(a_reg, mq); t0_reg <= r0[31:0];
                        sat_reg <= sat_reg | mclamp | r0[32];
                    end
                OP_U_MUL_K0B:
                    if (mdone)
                    begin
                        r0 = sub2(b_reg, mq); t1_reg <= r0[31:0];
                        sat_reg <= sat_reg | mclamp | r0[32];
                    end
                OP_U_MUL_K1A:
                    if (mdone)
                    begin
                        r0 = sub2(c_reg, mq); t2_reg <= r0[31:0];
                        sat_reg <= sat_reg | mclamp | r0[32];
                    end
                OP_U_MUL_K1B:
                    if (mdone)
                    begin
                        r0 = sub2(d_reg, mq);
                        a_reg <= t0_reg; b_reg <= t1_reg; c_reg <= t2_reg;
                        d_reg <= r0[31:0];
                        sat_reg <= sat_reg | mclamp | r0[32];
                    end
                default: ;
            endcase
        end
    end

    // Results register, loaded once per item and held until taken.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            angle_out <= ang_reg;
            rate_out  <= rate_reg;
            sing_out  <= sing_reg;
            sat_out   <= sat_reg;
        end
    end
endmodule
`default_nettype wire

/* src/kcv_ctrl.sv */
// Sequencer of the filter: walks the steps of each item kind.
`default_nettype none
module kcv_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic [1:0]    in_kind,
    input  wire logic          out_fire,
    input  wire kcv_pkg::stat_t stat,
    output kcv_pkg::cmd_t      cmd,
    output logic               in_ready,
    output logic               out_valid
);
    import kcv_pkg::*;
    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_NONE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ov_next    = ov_reg;
        cmd        = '{op: OP_NONE, mul_start: 1'b0, div_start: 1'b0, out_load: 1'b0};
        in_ready   = (state_reg == ST_IDLE) && !ov_reg;
        if (out_fire)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                    unique case (kind_t'(in_kind))
                        KIND_INIT:    op_next = OP_INIT;
                        KIND_PREDICT: op_next = OP_P_MUL_VC;
                        KIND_UPDATE:  op_next = OP_U_CHECK;
                        KIND_FORCE:   op_next = OP_FORCE;
                    endcase
                end
            ST_EXEC:
            begin
                cmd.op = op_reg;
                unique case (op_reg) inside
                    OP_INIT, OP_FORCE: state_next = ST_OUT;
                    OP_U_CHECK: op_next = OP_U_DIV0;
                    OP_U_DIV0:
                        if (stat.s_bad) state_next = ST_OUT;
                        else
                        begin
                            cmd.div_start = 1'b1;
                            op_next = OP_U_K0;
                            state_next = ST_DIV;
                        end
                    default:
                    begin
                        cmd.mul_start = 1'b1;
                        state_next = ST_MUL;
                    end
                endcase
            end
            ST_DIV:
            begin
                cmd.op = op_reg;
                if (stat.div_done)
                begin
                    if (op_reg == OP_U_K0)
                    begin
                        cmd.div_start = 1'b1;
                        op_next = OP_U_K1;
                    end
                    else
                    begin
                        op_next = OP_U_MUL_K0Y;
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.op = op_reg;
                if (stat.mul_done)
                begin
                    state_next = ST_EXEC;
                    unique case (op_reg)
                        OP_P_MUL_VC:  op_next = OP_P_MUL_VD;
                        OP_P_MUL_VD:  op_next = OP_P_MUL_VT1;
                        OP_P_MUL_VT1: op_next = OP_P_MUL_VR;
                        OP_U_MUL_K0Y: op_next = OP_U_MUL_K1Y;
                        OP_U_MUL_K1Y: op_next = OP_U_MUL_K0A;
                        OP_U_MUL_K0A: op_next = OP_U_MUL_K0B;
                        OP_U_MUL_K0B: op_next = OP_U_MUL_K1A;
                        OP_U_MUL_K1A: op_next = OP_U_MUL_K1B;
                        default:      state_next = ST_OUT;
                    endcase
                end
            end
            ST_OUT:
            begin
                if (!ov_reg)
                begin
                    cmd.out_load = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
endmodule
`default_nettype wire

/* src/kalman_cv_angle_rate.sv */
// Top level of the two-state angle/rate Kalman filter.
//
// channel  dir  handshake              payload
// s_axis   in   s_tvalid / s_tready    tdata: value[31:0]; tuser: kind[1:0]
// m_axis   out  m_tvalid / m_tready    tdata: angle, rate; tuser: singular, saturated
// apb      in   psel/penable/pready    5 registers at 4*i
//
// Initialize and force load the state directly; predict runs four multiply steps and
// update runs two one-bit-per-cycle gain divisions and six multiply steps before the
// result is valid; a skipped update runs none of them. Reset loads identity covariance
// and clears the estimates. A new item is taken once the previous result has been
// taken; a stalled output holds.
`default_nettype none
`include "kalman_cv_angle_rate_defines.svh"
module kalman_cv_angle_rate #(
    parameter int FRAC_BITS = kcv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [31:0]                s_tdata,  // value
    input  wire logic [1:0]                 s_tuser,  // kind
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [63:0]                     m_tdata,  // angle_estimate, rate_estimate
    output logic [1:0]                      m_tuser,  // singular, saturated
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [kcv_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import kcv_pkg::*;
    logic [31:0] qaa_reg, qar_reg, qra_reg, qrr_reg;
    logic [30:0] rn_reg;
    cmd_t  cmd;
    stat_t stat;
    logic  in_fire, out_fire, wr;
    logic signed [31:0] ang, rate;
    logic  sing, satf;

    assign pready   = 1'b1;
    assign wr       = psel && penable && pwrite;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qaa_reg <= 32'd66;
            qar_reg <= '0;
            qra_reg <= '0;
            qrr_reg <= 32'd655;
            rn_reg  <= 31'd6554;
        end
        else if (wr)
        begin
            unique case (paddr)
                ADDR_QAA: qaa_reg <= pwdata;
                ADDR_QAR: qar_reg <= pwdata;
                ADDR_QRA: qra_reg <= pwdata;
                ADDR_QRR: qrr_reg <= pwdata;
                ADDR_RN:  rn_reg  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_QAA: prdata = qaa_reg;
            ADDR_QAR: prdata = qar_reg;
            ADDR_QRA: prdata = qra_reg;
            ADDR_QRR: prdata = qrr_reg;
            ADDR_RN:  prdata = {1'b0, rn_reg};
            default:  prdata = '0;
        endcase
    end

    kcv_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_kind(s_tuser),
        .out_fire(out_fire), .stat(stat), .cmd(cmd), .in_ready(s_tready),
        .out_valid(m_tvalid)
    );

    kcv_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_load(in_fire),
        .in_value(s_tdata), .qaa(qaa_reg), .qar(qar_reg), .qra(qra_reg),
        .qrr(qrr_reg), .rn(rn_reg), .angle_out(ang), .rate_out(rate),
        .sing_out(sing), .sat_out(satf)
    );

    assign m_tdata = {rate, ang};
    assign m_tuser = {satf, sing};

    `KCV_ASSERT_IMP(a_no_accept_busy, clk, rst_n, m_tvalid, !s_tready)
    `KCV_ASSERT_IMP(a_one_start, clk, rst_n, cmd.mul_start, !cmd.div_start)
    `KCV_ASSERT_NXT(a_load_valid, clk, rst_n, cmd.out_load, m_tvalid)
endmodule
`default_nettype wire
